// File: hdl/stp_pkg.sv
// Shared types and constants for the SAUCE trailer parser.
// No dependencies; imported by every module of the block.
package stp_pkg;

    // Record window geometry and byte positions inside the window.
    localparam logic [7:0] WINDOW_LEN   = 8'd128;
    localparam logic [6:0] POS_DATATYPE = 7'd94;
    localparam logic [6:0] POS_FILETYPE = 7'd95;
    localparam logic [6:0] POS_TINFO1   = 7'd96;
    localparam logic [6:0] POS_FLAGS    = 7'd105;
    localparam logic [6:0] TEXT_START   = 7'd106;

    // Depth of the kept-character history used for keyword matching.
    localparam int TXT_WIN_DEPTH = 7;
    localparam int NUM_KEYWORDS  = 10;

    // Keyword bit positions in keyword_seen.
    localparam int KW_VGA      = 0;
    localparam int KW_EGA      = 1;
    localparam int KW_VGA50    = 2;
    localparam int KW_EGA43    = 3;
    localparam int KW_TOPAZ    = 4;
    localparam int KW_KNIGHT   = 5;
    localparam int KW_MOSOUL   = 6;
    localparam int KW_NOODLE   = 7;
    localparam int KW_TERMINUS = 8;
    localparam int KW_SPLEEN   = 9;

    // Result status codes.
    localparam logic [2:0] ST_TOO_SMALL    = 3'd0;
    localparam logic [2:0] ST_NO_HEADER    = 3'd1;
    localparam logic [2:0] ST_BAD_FILETYPE = 3'd2;
    localparam logic [2:0] ST_BAD_DATATYPE = 3'd3;
    localparam logic [2:0] ST_IGNORED      = 3'd4;
    localparam logic [2:0] ST_USED         = 3'd5;
    localparam logic [2:0] ST_USED_UNKNOWN = 3'd6;

    // State of the font-name text tracker.
    typedef struct packed {
        logic                              text_ended;
        logic [15:0]                       digit_value;
        logic                              in_digits;
        logic                              ends_plus;
        logic [1:0]                        prefix_count;
        logic                              prefix_ok;
        logic [TXT_WIN_DEPTH-1:0][7:0]     char_window;
        logic [NUM_KEYWORDS-1:0]           keyword_seen;
    } txt_state_t;

    // Per-byte control for the text tracker.
    typedef struct packed {
        logic       step;
        logic       clear;
        logic [7:0] data;
    } txt_ctrl_t;

    // Fixed-position fields captured from the record.
    typedef struct packed {
        logic       window_full;
        logic       header_match;
        logic [7:0] record_type;
        logic [7:0] file_kind;
        logic [7:0] width_info;
        logic [7:0] flag_byte;
    } rec_fields_t;

    // One result transaction.
    typedef struct packed {
        logic [2:0] status;
        logic       has_record;
        logic       auto_columns;
        logic [8:0] column_count;
        logic       ice_colors;
        logic [1:0] letter_width_mode;
        logic [1:0] aspect_mode;
        logic [4:0] font_code;
    } res_t;

endpackage

// File: hdl/stp_text_tracker.sv
// Font-name text tracker: canonicalizes the text and tracks prefix, keywords,
// the last digit run and a trailing plus sign. Depends on stp_pkg.
module stp_text_tracker
    import stp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  txt_ctrl_t  ctrl,
    output txt_state_t state_next
);

    // Keywords stored with the last character at byte 0.
    localparam logic [7:0][7:0] KW_REV [NUM_KEYWORDS] = '{
        64'("vga"), 64'("ega"), 64'("vga50"), 64'("ega43"), 64'("topaz"),
        64'("knight"), 64'("mosoul"), 64'("noodle"), 64'("terminus"), 64'("spleen")
    };
    localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
        4'd3, 4'd3, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd8, 4'd6
    };

    localparam txt_state_t TXT_RESET = '{
        text_ended:   1'b0,
        digit_value:  16'd0,
        in_digits:    1'b0,
        ends_plus:    1'b0,
        prefix_count: 2'd0,
        prefix_ok:    1'b1,
        char_window:  '0,
        keyword_seen: '0
    };

    function automatic logic [NUM_KEYWORDS-1:0] keyword_hits(
        input logic [7:0] c,
        input logic [TXT_WIN_DEPTH-1:0][7:0] win
    );
        logic [NUM_KEYWORDS-1:0] hits;
        hits = '0;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            hits[k] = (c == KW_REV[k][0]);
            for (int j = 0; j < TXT_WIN_DEPTH; j++) begin
                if ((j + 1 < int'(KW_LEN[k])) && (win[j] != KW_REV[k][j+1])) begin
                    hits[k] = 1'b0;
                end
            end
        end
        return hits;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0:    ch = "i";
            2'd1:    ch = "b";
            default: ch = "m";
        endcase
        return ch;
    endfunction

    txt_state_t state_reg;

    logic [7:0]  c;
    logic        is_upper;
    logic        is_lower;
    logic        is_digit;
    logic        keep;
    logic [7:0]  kept_char;
    logic [19:0] digit_base;
    logic [19:0] digit_prod;

    assign c        = ctrl.data;
    assign is_upper = (c >= "A") && (c <= "Z");
    assign is_lower = (c >= "a") && (c <= "z");
    assign is_digit = (c >= "0") && (c <= "9");
    assign keep     = is_upper || is_lower || is_digit;
    assign kept_char = is_upper ? (c | 8'h20) : c;

    // Multiply-by-ten accumulate; ASCII digits carry their value in the low nibble.
    assign digit_base = state_reg.in_digits ? {4'd0, state_reg.digit_value} : 20'd0;
    assign digit_prod = (digit_base << 3) + (digit_base << 1) + {16'd0, c[3:0]};

    always_comb begin
        state_next = state_reg;
        if (ctrl.step && !state_reg.text_ended) begin
            if (c == 8'd0) begin
                state_next.text_ended = 1'b1;
            end else begin
                state_next.ends_plus = (c == "+");
                state_next.in_digits = is_digit;
                if (is_digit) begin
                    state_next.digit_value = (digit_prod[19:16] != 4'd0) ? 16'hFFFF
                                                                         : digit_prod[15:0];
                end
                if (keep) begin
                    if (state_reg.prefix_count != 2'd3) begin
                        if (kept_char != prefix_char(state_reg.prefix_count)) begin
                            state_next.prefix_ok = 1'b0;
                        end
                        state_next.prefix_count = state_reg.prefix_count + 2'd1;
                    end
                    state_next.keyword_seen = state_reg.keyword_seen |
                                              keyword_hits(kept_char, state_reg.char_window);
                    state_next.char_window = {state_reg.char_window[TXT_WIN_DEPTH-2:0],
                                              kept_char};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            state_reg <= TXT_RESET;
        end else if (ctrl.step) begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/stp_result_build.sv
// Result builder: status decision, column settings, flag decoding and font pick.
// Purely combinational; depends on stp_pkg.
module stp_result_build
    import stp_pkg::*;
(
    input  rec_fields_t rec,
    input  txt_state_t  txt,
    input  logic        use_sauce,
    output res_t        res
);

    localparam int NUM_CODEPAGES = 13;
    localparam logic [15:0] CODEPAGE_NUM [NUM_CODEPAGES] = '{
        16'd737, 16'd775, 16'd850, 16'd852, 16'd855, 16'd857, 16'd860,
        16'd861, 16'd862, 16'd863, 16'd865, 16'd866, 16'd869
    };

    localparam logic [4:0] FONT_UNKNOWN        = 5'd0;
    localparam logic [4:0] FONT_TOPAZ          = 5'd1;
    localparam logic [4:0] FONT_TOPAZ_PLUS     = 5'd2;
    localparam logic [4:0] FONT_TOPAZ500       = 5'd3;
    localparam logic [4:0] FONT_TOPAZ500_PLUS  = 5'd4;
    localparam logic [4:0] FONT_MKNIGHT        = 5'd5;
    localparam logic [4:0] FONT_MKNIGHT_PLUS   = 5'd6;
    localparam logic [4:0] FONT_MOSOUL         = 5'd7;
    localparam logic [4:0] FONT_NOODLE         = 5'd8;
    localparam logic [4:0] FONT_TERMINUS       = 5'd9;
    localparam logic [4:0] FONT_SPLEEN         = 5'd10;
    localparam logic [4:0] FONT_CP437          = 5'd11;
    localparam logic [4:0] FONT_CP437_80X50    = 5'd12;
    localparam logic [4:0] FONT_CODEPAGE_FIRST = 5'd13;

    logic [2:0] base_status;
    logic [8:0] columns;
    logic       ibm_family;
    logic       cp_found;
    logic [4:0] cp_font;
    logic [4:0] font;
    logic [1:0] lw;
    logic [1:0] asp;

    always_comb begin
        columns = 9'd0;
        priority if (!rec.window_full) begin
            base_status = ST_TOO_SMALL;
        end else if (!rec.header_match) begin
            base_status = ST_NO_HEADER;
        end else if (rec.record_type == 8'd1) begin
            if (rec.file_kind <= 8'd2) begin
                base_status = ST_IGNORED;
                columns     = {1'b0, rec.width_info};
            end else begin
                base_status = ST_BAD_FILETYPE;
            end
        end else if (rec.record_type == 8'd5) begin
            base_status = ST_IGNORED;
            columns     = {rec.file_kind, 1'b0};
        end else begin
            base_status = ST_BAD_DATATYPE;
        end
    end

    always_comb begin
        cp_found = 1'b0;
        cp_font  = FONT_CP437;
        for (int i = NUM_CODEPAGES - 1; i >= 0; i--) begin
            if (txt.digit_value == CODEPAGE_NUM[i]) begin
                cp_found = 1'b1;
                cp_font  = FONT_CODEPAGE_FIRST + 5'(i);
            end
        end
    end

    assign ibm_family = ((txt.prefix_count == 2'd3) && txt.prefix_ok) ||
                        txt.keyword_seen[KW_VGA] || txt.keyword_seen[KW_EGA];

    always_comb begin
        priority if (ibm_family) begin
            if (txt.keyword_seen[KW_VGA50] || txt.keyword_seen[KW_EGA43]) begin
                font = FONT_CP437_80X50;
            end else begin
                font = cp_found ? cp_font : FONT_CP437;
            end
        end else if (txt.keyword_seen[KW_TOPAZ]) begin
            if (txt.digit_value == 16'd1) begin
                font = txt.ends_plus ? FONT_TOPAZ500_PLUS : FONT_TOPAZ500;
            end else begin
                font = txt.ends_plus ? FONT_TOPAZ_PLUS : FONT_TOPAZ;
            end
        end else if (txt.keyword_seen[KW_KNIGHT]) begin
            font = txt.ends_plus ? FONT_MKNIGHT_PLUS : FONT_MKNIGHT;
        end else if (txt.keyword_seen[KW_MOSOUL]) begin
            font = FONT_MOSOUL;
        end else if (txt.keyword_seen[KW_NOODLE]) begin
            font = FONT_NOODLE;
        end else if (txt.keyword_seen[KW_TERMINUS]) begin
            font = FONT_TERMINUS;
        end else if (txt.keyword_seen[KW_SPLEEN]) begin
            font = FONT_SPLEEN;
        end else begin
            font = FONT_UNKNOWN;
        end
    end

    assign lw  = rec.flag_byte[2:1];
    assign asp = rec.flag_byte[4:3];

    always_comb begin
        res = '0;
        if ((base_status == ST_IGNORED) && use_sauce) begin
            res.status            = (font != FONT_UNKNOWN) ? ST_USED : ST_USED_UNKNOWN;
            res.auto_columns      = (columns == 9'd0);
            res.column_count      = columns;
            res.ice_colors        = rec.flag_byte[0];
            res.letter_width_mode = ((lw == 2'd1) || (lw == 2'd2)) ? lw : 2'd0;
            res.aspect_mode       = ((asp == 2'd1) || (asp == 2'd2)) ? asp : 2'd0;
            res.font_code         = font;
        end else begin
            res.status = base_status;
        end
        res.has_record = (res.status >= ST_IGNORED);
    end

endmodule

// File: hdl/sauce_trailer_parser.sv
// Top level of the SAUCE trailer parser: input register, record field capture,
// output register. Depends on stp_pkg, stp_text_tracker and stp_result_build.
//
// Usage:
//   Feed the final 128 bytes of a text-art file (or the whole file if it is
//   shorter) on the s_ channel, one byte per transaction, with s_last set on
//   the final byte of the file. Bytes past the 128th are ignored until the
//   one marked last, which always closes the file.
//   Exactly one result transaction leaves on the m_ channel per file, after
//   the byte marked last: status, column settings, flag decisions and font.
//   Throughput is one byte per cycle, but a last byte holds while an earlier
//   result still waits (see below). Each accepted byte sits in the input register,
//   and its update of the parser state is done in one pass of logic; the
//   result for a last byte is loaded into the output register as that byte
//   leaves the input register, and m_valid rises with it.
//   While a result waits on m_ready, non-last bytes keep flowing; only a
//   further last byte holds in the input register until the output frees.
//   cfg_wr_en/cfg_wr_data write use_sauce (reset 1) at any edge; write it
//   only while no file is in progress.
//   Reset (aresetn low, synchronous) clears all parser state, empties both
//   registers and sets use_sauce. After each result the parser state returns
//   to its reset value by itself, ready for the next file.
module sauce_trailer_parser
    import stp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic       m_has_record,
    output logic       m_auto_columns,
    output logic [8:0] m_column_count,
    output logic       m_ice_colors,
    output logic [1:0] m_letter_width_mode,
    output logic [1:0] m_aspect_mode,
    output logic [4:0] m_font_code,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data
);

    // Expected signature character at a window position below five.
    function automatic logic [7:0] sig_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = "S";
            3'd1:    ch = "A";
            3'd2:    ch = "U";
            3'd3:    ch = "C";
            default: ch = "E";
        endcase
        return ch;
    endfunction

    // Configuration.
    logic use_sauce_reg;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    // Record capture state.
    logic [7:0]  byte_count_reg;
    logic [7:0]  byte_count_next;
    rec_fields_t rec_reg;
    rec_fields_t rec_next;

    // Output register.
    logic m_valid_reg;
    res_t res_reg;
    res_t res_comb;

    logic       advance;
    logic       in_window;
    logic [6:0] idx;
    logic       text_active;
    txt_ctrl_t  txt_ctrl;
    txt_state_t txt_next;

    // The held byte moves on unless it is a last byte and the output is full.
    assign advance = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign in_window   = (byte_count_reg < WINDOW_LEN);
    assign idx         = byte_count_reg[6:0];
    assign text_active = in_window && (idx >= TEXT_START);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_sauce_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            use_sauce_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last;
        end
    end

    // Byte count saturates at the window length; fixed fields are captured
    // at their positions.
    always_comb begin
        byte_count_next = byte_count_reg;
        rec_next        = rec_reg;
        if (in_window) begin
            byte_count_next = byte_count_reg + 8'd1;
            if ((idx < 7'd5) && (in_data_reg != sig_char(idx[2:0]))) begin
                rec_next.header_match = 1'b0;
            end
            if (idx == POS_DATATYPE) rec_next.record_type = in_data_reg;
            if (idx == POS_FILETYPE) rec_next.file_kind   = in_data_reg;
            if (idx == POS_TINFO1)   rec_next.width_info  = in_data_reg;
            if (idx == POS_FLAGS)    rec_next.flag_byte   = in_data_reg;
        end
        rec_next.window_full = (byte_count_next >= WINDOW_LEN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_last_reg)) begin
            byte_count_reg       <= 8'd0;
            rec_reg.window_full  <= 1'b0;
            rec_reg.header_match <= 1'b1;
            rec_reg.record_type  <= 8'd0;
            rec_reg.file_kind    <= 8'd0;
            rec_reg.width_info   <= 8'd0;
            rec_reg.flag_byte    <= 8'd0;
        end else if (advance) begin
            byte_count_reg <= byte_count_next;
            rec_reg        <= rec_next;
        end
    end

    assign txt_ctrl.step  = advance && text_active;
    assign txt_ctrl.clear = advance && in_last_reg;
    assign txt_ctrl.data  = in_data_reg;

    stp_text_tracker u_text (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (txt_ctrl),
        .state_next (txt_next)
    );

    // The result sees the state as updated by the last byte itself.
    stp_result_build u_result (
        .rec       (rec_next),
        .txt       (txt_next),
        .use_sauce (use_sauce_reg),
        .res       (res_comb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            res_reg <= res_comb;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = res_reg.status;
    assign m_has_record        = res_reg.has_record;
    assign m_auto_columns      = res_reg.auto_columns;
    assign m_column_count      = res_reg.column_count;
    assign m_ice_colors        = res_reg.ice_colors;
    assign m_letter_width_mode = res_reg.letter_width_mode;
    assign m_aspect_mode       = res_reg.aspect_mode;
    assign m_font_code         = res_reg.font_code;

`ifndef NO_ASSERTIONS
    // A result is never overwritten while it still waits.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !(advance && in_last_reg))
        else $error("result register overwritten while stalled");

    // The byte counter never runs past the window length.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= WINDOW_LEN)
        else $error("byte counter beyond window");

    // Closing a file restarts the counter for the next one.
    a_count_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (byte_count_reg == 8'd0))
        else $error("byte counter not cleared after a result");

    // Results without an applied record carry no settings.
    a_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (res_reg.status < ST_USED)) |->
        ((res_reg.font_code == 5'd0) && (res_reg.column_count == 9'd0) &&
         !res_reg.auto_columns))
        else $error("settings present on a result that does not use the record");

    // Used status, font code and record flag agree.
    a_font_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (((res_reg.status == ST_USED) == (res_reg.font_code != 5'd0)) &&
                         (res_reg.has_record == (res_reg.status >= ST_IGNORED))))
        else $error("status, record flag and font code disagree");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for sauce_trailer_parser: streams trailer windows byte by byte,
// predicts each per-file result in step with the accepted bytes and checks it field by field.
// Depends on stp_pkg and the sauce_trailer_parser RTL; needs nothing else.
module tb_top;
    import stp_pkg::*;

    // Run control.
    localparam int WATCHDOG_LIMIT   = 3000;  // cycles with no accepted transaction
    localparam int DRAIN_CYCLES     = 4;     // idle margin after the last result is out
    localparam int RANDOM_BYTES     = 1850;
    localparam int MIN_RANDOM_FILES = 40;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int FONT_FIELD_LEN   = 22;    // bytes 106..127 of the window
    localparam int NUM_BASE_FONTS   = 20;

    // Record data types the parser accepts.
    localparam logic [7:0] DT_CHARACTER = 8'd1;
    localparam logic [7:0] DT_BINARY    = 8'd5;

    // Flag decodes.
    localparam logic [1:0] LW_KEEP = 2'd0;
    localparam logic [1:0] LW_8PX  = 2'd1;
    localparam logic [1:0] LW_9PX  = 2'd2;
    localparam logic [1:0] AR_KEEP = 2'd0;
    localparam logic [1:0] AR_ON   = 2'd1;
    localparam logic [1:0] AR_OFF  = 2'd2;

    // Font codes in the order of the font list.
    localparam logic [4:0] FONT_UNKNOWN       = 5'd0;
    localparam logic [4:0] FONT_TOPAZ         = 5'd1;
    localparam logic [4:0] FONT_TOPAZ_PLUS    = 5'd2;
    localparam logic [4:0] FONT_TOPAZ500      = 5'd3;
    localparam logic [4:0] FONT_TOPAZ500_PLUS = 5'd4;
    localparam logic [4:0] FONT_UKNIGHT       = 5'd5;
    localparam logic [4:0] FONT_UKNIGHT_PLUS  = 5'd6;
    localparam logic [4:0] FONT_MOSOUL        = 5'd7;
    localparam logic [4:0] FONT_NOODLE        = 5'd8;
    localparam logic [4:0] FONT_TERMINUS      = 5'd9;
    localparam logic [4:0] FONT_SPLEEN        = 5'd10;
    localparam logic [4:0] FONT_CP437         = 5'd11;
    localparam logic [4:0] FONT_CP437_50      = 5'd12;
    localparam logic [4:0] FONT_CP_FIRST      = 5'd13;  // cp737, then the rest in order

    localparam logic [39:0] SIGNATURE  = "SAUCE";
    localparam logic [23:0] IBM_PREFIX = "ibm";

    typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_SPARSE} rx_mode_e;

    // Clock, reset and block inputs, all at known values from time zero.
    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_last      = 1'b0;
    logic       m_ready     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;

    logic       s_ready;
    logic       m_valid;
    logic [2:0] m_status;
    logic       m_has_record;
    logic       m_auto_columns;
    logic [8:0] m_column_count;
    logic       m_ice_colors;
    logic [1:0] m_letter_width_mode;
    logic [1:0] m_aspect_mode;
    logic [4:0] m_font_code;

    always #10 aclk = ~aclk;

    sauce_trailer_parser DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_data_byte         (s_data_byte),
        .s_last              (s_last),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_has_record        (m_has_record),
        .m_auto_columns      (m_auto_columns),
        .m_column_count      (m_column_count),
        .m_ice_colors        (m_ice_colors),
        .m_letter_width_mode (m_letter_width_mode),
        .m_aspect_mode       (m_aspect_mode),
        .m_font_code         (m_font_code),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data)
    );

    // Expected results, oldest first, and the run's bookkeeping.
    res_t       expected_q[$];
    logic [7:0] file_q[$];      // the file currently being built for sending
    logic [7:0] font_q[$];      // font-name text placed at the start of the text field
    int         error_count     = 0;
    int         bytes_sent      = 0;
    int         files_sent      = 0;
    int         results_checked = 0;
    int         cfg_writes      = 0;
    int         status_hits[8];
    int         burst_left      = 0;
    bit         sender_gaps     = 1'b1;
    int         rx_hold_req     = 0;

    // Shadow of the parser: the register copy and the per-file state.
    logic                    sauce_on = 1'b1;
    logic [7:0]              pr_count;
    logic                    pr_sig_ok;
    logic [7:0]              pr_dtype;
    logic [7:0]              pr_ftype;
    logic [7:0]              pr_tinfo;
    logic [7:0]              pr_flags;
    logic                    pr_txt_done;
    logic [15:0]             pr_num;
    logic                    pr_in_num;
    logic                    pr_plus;
    logic [1:0]              pr_ibm_cnt;
    logic                    pr_ibm_ok;
    logic [7:0]              pr_hist[TXT_WIN_DEPTH];  // [0] is the newest kept character
    logic [NUM_KEYWORDS-1:0] pr_kw;

    // Keyword text, right-justified so that its last character sits in bits 7:0.
    function automatic logic [63:0] kw_text(int k);
        case (k)
            KW_VGA:      return "vga";
            KW_EGA:      return "ega";
            KW_VGA50:    return "vga50";
            KW_EGA43:    return "ega43";
            KW_TOPAZ:    return "topaz";
            KW_KNIGHT:   return "knight";
            KW_MOSOUL:   return "mosoul";
            KW_NOODLE:   return "noodle";
            KW_TERMINUS: return "terminus";
            default:     return "spleen";
        endcase
    endfunction

    function automatic int kw_len(int k);
        case (k)
            KW_VGA, KW_EGA:                      return 3;
            KW_VGA50, KW_EGA43, KW_TOPAZ:        return 5;
            KW_TERMINUS:                         return 8;
            default:                             return 6;
        endcase
    endfunction

    // Code pages with a font of their own, in font-code order.
    function automatic int cp_num(int i);
        case (i)
            0:       return 737;
            1:       return 775;
            2:       return 850;
            3:       return 852;
            4:       return 855;
            5:       return 857;
            6:       return 860;
            7:       return 861;
            8:       return 862;
            9:       return 863;
            10:      return 865;
            11:      return 866;
            default: return 869;
        endcase
    endfunction

    function automatic void clear_parser();
        pr_count    = 8'd0;
        pr_sig_ok   = 1'b1;
        pr_dtype    = 8'd0;
        pr_ftype    = 8'd0;
        pr_tinfo    = 8'd0;
        pr_flags    = 8'd0;
        pr_txt_done = 1'b0;
        pr_num      = 16'd0;
        pr_in_num   = 1'b0;
        pr_plus     = 1'b0;
        pr_ibm_cnt  = 2'd0;
        pr_ibm_ok   = 1'b1;
        pr_kw       = '0;
        for (int j = 0; j < TXT_WIN_DEPTH; j++) pr_hist[j] = 8'd0;
    endfunction

    // A kept character updates the prefix check, the keyword hits and the history.
    function automatic void keep_char(logic [7:0] c);
        logic [63:0] txt;
        int          len;
        bit          hit;
        if (pr_ibm_cnt < 2'd3) begin
            if (c != IBM_PREFIX[8*(2-pr_ibm_cnt) +: 8]) pr_ibm_ok = 1'b0;
            pr_ibm_cnt++;
        end
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            txt = kw_text(k);
            len = kw_len(k);
            hit = (c == txt[7:0]);
            for (int j = 0; j < len - 1; j++) begin
                if (pr_hist[j] != txt[8*(j+1) +: 8]) hit = 1'b0;
            end
            if (hit) pr_kw[k] = 1'b1;
        end
        for (int j = TXT_WIN_DEPTH - 1; j > 0; j--) pr_hist[j] = pr_hist[j-1];
        pr_hist[0] = c;
    endfunction

    // Font-name canonicalization: letters lowercased, digits kept, the rest dropped.
    function automatic void text_byte(logic [7:0] c);
        int unsigned v;
        if (pr_txt_done) return;
        if (c == 8'h00) begin
            pr_txt_done = 1'b1;
            return;
        end
        pr_plus = (c == "+");
        if (c >= "A" && c <= "Z") begin
            pr_in_num = 1'b0;
            keep_char(c + 8'd32);
        end else if (c >= "a" && c <= "z") begin
            pr_in_num = 1'b0;
            keep_char(c);
        end else if (c >= "0" && c <= "9") begin
            v = pr_in_num ? pr_num : 0;
            v = v * 10 + (c - "0");
            pr_num = (v > 65535) ? 16'hFFFF : v[15:0];
            pr_in_num = 1'b1;
            keep_char(c);
        end else begin
            pr_in_num = 1'b0;
        end
    endfunction

    function automatic logic [4:0] pick_font();
        bit ibm;
        ibm = (pr_ibm_cnt == 2'd3) && pr_ibm_ok;
        if (ibm || pr_kw[KW_VGA] || pr_kw[KW_EGA]) begin
            if (pr_kw[KW_VGA50] || pr_kw[KW_EGA43]) return FONT_CP437_50;
            for (int i = 0; i < 13; i++) begin
                if (pr_num == cp_num(i)) return 5'(FONT_CP_FIRST + i);
            end
            return FONT_CP437;
        end
        if (pr_kw[KW_TOPAZ]) begin
            if (pr_num == 16'd1) return pr_plus ? FONT_TOPAZ500_PLUS : FONT_TOPAZ500;
            return pr_plus ? FONT_TOPAZ_PLUS : FONT_TOPAZ;
        end
        if (pr_kw[KW_KNIGHT])   return pr_plus ? FONT_UKNIGHT_PLUS : FONT_UKNIGHT;
        if (pr_kw[KW_MOSOUL])   return FONT_MOSOUL;
        if (pr_kw[KW_NOODLE])   return FONT_NOODLE;
        if (pr_kw[KW_TERMINUS]) return FONT_TERMINUS;
        if (pr_kw[KW_SPLEEN])   return FONT_SPLEEN;
        return FONT_UNKNOWN;
    endfunction

    // Advances the shadow parser by one accepted byte. Returns 1 with the
    // expected result when the byte closes the file.
    function automatic bit predict_result(logic [7:0] b, logic lst, output res_t r);
        logic [2:0] st;
        logic [8:0] cols;
        logic [4:0] font;
        logic [1:0] lw;
        logic [1:0] asp;
        cols = 9'd0;
        if (pr_count < WINDOW_LEN) begin
            if (pr_count < 8'd5 && b != SIGNATURE[8*(4-pr_count) +: 8]) pr_sig_ok = 1'b0;
            if (pr_count == POS_DATATYPE) pr_dtype = b;
            if (pr_count == POS_FILETYPE) pr_ftype = b;
            if (pr_count == POS_TINFO1)   pr_tinfo = b;
            if (pr_count == POS_FLAGS)    pr_flags = b;
            if (pr_count >= TEXT_START)   text_byte(b);
            pr_count++;
        end
        r = '0;
        if (!lst) return 1'b0;

        if (pr_count < WINDOW_LEN) st = ST_TOO_SMALL;
        else if (!pr_sig_ok) st = ST_NO_HEADER;
        else if (pr_dtype == DT_CHARACTER) begin
            if (pr_ftype <= 8'd2) begin
                st = ST_IGNORED;
                cols = {1'b0, pr_tinfo};
            end else begin
                st = ST_BAD_FILETYPE;
            end
        end else if (pr_dtype == DT_BINARY) begin
            st = ST_IGNORED;
            cols = {pr_ftype, 1'b0};
        end else begin
            st = ST_BAD_DATATYPE;
        end

        if (st == ST_IGNORED && sauce_on) begin
            font = pick_font();
            st = (font != FONT_UNKNOWN) ? ST_USED : ST_USED_UNKNOWN;
            lw = pr_flags[2:1];
            asp = pr_flags[4:3];
            r.auto_columns      = (cols == 9'd0);
            r.column_count      = cols;
            r.ice_colors        = pr_flags[0];
            r.letter_width_mode = (lw == LW_8PX || lw == LW_9PX) ? lw : LW_KEEP;
            r.aspect_mode       = (asp == AR_ON || asp == AR_OFF) ? asp : AR_KEEP;
            r.font_code         = font;
        end
        r.status = st;
        r.has_record = (st >= ST_IGNORED);
        clear_parser();
        return 1'b1;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(string name, logic [15:0] got_v, logic [15:0] want_v);
        if (got_v !== want_v)
            report_error($sformatf("result %0d field %s: got %0d, expected %0d",
                                   results_checked, name, got_v, want_v));
    endtask

    // Every result transaction is checked against the oldest expectation.
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (m_valid && m_ready) begin
            got = {m_status, m_has_record, m_auto_columns, m_column_count, m_ice_colors,
                   m_letter_width_mode, m_aspect_mode, m_font_code};
            if (expected_q.size() == 0) begin
                report_error($sformatf("result transaction with status %0d but no file closed",
                                       got.status));
            end else begin
                want = expected_q.pop_front();
                compare_field("status", got.status, want.status);
                compare_field("has_record", got.has_record, want.has_record);
                compare_field("auto_columns", got.auto_columns, want.auto_columns);
                compare_field("column_count", got.column_count, want.column_count);
                compare_field("ice_colors", got.ice_colors, want.ice_colors);
                compare_field("letter_width_mode", got.letter_width_mode, want.letter_width_mode);
                compare_field("aspect_mode", got.aspect_mode, want.aspect_mode);
                compare_field("font_code", got.font_code, want.font_code);
            end
            status_hits[got.status]++;
            results_checked++;
        end
    end

    // The receiver stalls in phases of random length and mood. A test can ask it
    // for one long hold-off, which it counts down here in cycles.
    initial begin : receiver
        int       hold_left;
        int       phase_left;
        rx_mode_e mode;
        hold_left = 0;
        phase_left = 0;
        mode = RX_ALWAYS;
        forever begin
            @(posedge aclk);
            if (rx_hold_req > 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(1, 64);
                    mode = rx_mode_e'($urandom_range(0, 2));
                end
                phase_left--;
                case (mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_HALF:   m_ready <= 1'($urandom_range(0, 1));
                    default:   m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // The watchdog ends a run that has stopped moving. Any accepted transaction
    // on either channel restarts the count.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Watchdog: no transaction for %0d cycles, %0d results still expected",
                 WATCHDOG_LIMIT, expected_q.size());
        $display("Some tests failed");
        $finish;
    end

    // Offers one byte and waits for its transaction. The sender works in bursts;
    // between bursts valid drops for a random gap. Valid is never dropped at the
    // end of a byte, so back-to-back bytes keep it high without a glitch.
    task automatic send_byte(logic [7:0] b, logic lst);
        int   gap;
        res_t r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = sender_gaps ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last      <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // The byte was taken at this edge, so the shadow parser steps now.
        if (predict_result(b, lst, r)) expected_q.push_back(r);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
        files_sent++;
    endtask

    task automatic wait_drain();
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    // Stops offering, lets every pending result out and then a few more cycles,
    // so that the block holds no file when the register is touched.
    task automatic wait_idle();
        s_valid <= 1'b0;
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_use_sauce(logic v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sauce_on = v;
        cfg_writes++;
    endtask

    function automatic void set_font(string s);
        font_q.delete();
        for (int i = 0; i < s.len(); i++) font_q.push_back(s[i]);
    endfunction

    // A full window with the given fields and the current font text, plus
    // extra trailing bytes that fall past the window.
    function automatic void build_record(logic [7:0] dtype, logic [7:0] ftype,
                                         logic [7:0] tinfo, logic [7:0] flags,
                                         int bad_sig_pos, int extra);
        logic [7:0] b;
        file_q.delete();
        for (int i = 0; i < WINDOW_LEN; i++) begin
            b = 8'($urandom_range(0, 255));
            if (i < 5) b = SIGNATURE[8*(4-i) +: 8];
            if (i == bad_sig_pos) b = b ^ 8'($urandom_range(1, 255));
            if (i == POS_DATATYPE) b = dtype;
            if (i == POS_FILETYPE) b = ftype;
            if (i == POS_TINFO1) b = tinfo;
            if (i == POS_FLAGS) b = flags;
            if (i >= TEXT_START) begin
                // Text, then its terminator if it fits, then junk the parser must skip.
                if (i - TEXT_START < font_q.size()) b = font_q[i - TEXT_START];
                else if (i - TEXT_START == font_q.size()) b = 8'h00;
            end
            file_q.push_back(b);
        end
        repeat (extra) file_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_short(int len, bit with_sig);
        file_q.delete();
        for (int i = 0; i < len; i++) begin
            if (with_sig && i < 5) file_q.push_back(SIGNATURE[8*(4-i) +: 8]);
            else file_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Font names that steer the font decision down each of its branches.
    function automatic string base_font(int i);
        case (i)
            0:       return "IBM VGA";
            1:       return "IBM VGA50";
            2:       return "IBM EGA43";
            3:       return "ega";
            4:       return "IBM VGA 850";
            5:       return "IBM EGA 869";
            6:       return "Amiga Topaz 1";
            7:       return "Amiga Topaz 1+";
            8:       return "Amiga Topaz 2";
            9:       return "Amiga Topaz 2+";
            10:      return "Amiga MicroKnight";
            11:      return "Amiga MicroKnight+";
            12:      return "Amiga mOsOul";
            13:      return "Amiga P0T-NOoDLE";
            14:      return "Terminus";
            15:      return "Spleen";
            16:      return "";
            17:      return "IBM VGA 9999999";
            18:      return "x-ibm+vga 866, long name field!";
            default: return "Unknown 42";
        endcase
    endfunction

    // Random font text: a known name with random case and separators, a code
    // page number, or plain byte noise.
    function automatic void make_random_font();
        int         pick;
        int unsigned num;
        logic [7:0] c;
        string      name;
        pick = $urandom_range(0, 9);
        font_q.delete();
        if (pick == 0) begin
            repeat ($urandom_range(0, FONT_FIELD_LEN))
                font_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (pick == 1) begin
            num = $urandom_range(0, 1) ? cp_num($urandom_range(0, 12)) : $urandom_range(0, 99999);
            name = $sformatf("IBM VGA %0d", num);
        end else begin
            name = base_font($urandom_range(0, NUM_BASE_FONTS - 1));
        end
        for (int i = 0; i < name.len(); i++) begin
            c = name[i];
            if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 3) == 0)
                c = c ^ 8'h20;
            else if (c == " ") begin
                case ($urandom_range(0, 4))
                    0:       c = " ";
                    1:       c = "-";
                    2:       c = "_";
                    3:       c = 8'hB0;
                    default: c = 8'hFF;
                endcase
            end
            font_q.push_back(c);
        end
        if ($urandom_range(0, 4) == 0) font_q.push_back("+");
    endfunction

    // Mostly well-formed records with random content; the rest are short
    // files, broken signatures and unsupported types.
    function automatic void make_random_file();
        int         r;
        logic [7:0] dtype;
        logic [7:0] ftype;
        logic [7:0] tinfo;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            build_short($urandom_range(1, 40), 1'($urandom_range(0, 1)));
            return;
        end
        make_random_font();
        case ($urandom_range(0, 19))
            0, 1, 2:    dtype = DT_BINARY;
            3, 4, 5, 6: dtype = DT_BINARY;
            7, 8:       dtype = 8'($urandom_range(0, 255));
            default:    dtype = DT_CHARACTER;
        endcase
        if (dtype == DT_CHARACTER && $urandom_range(0, 4) != 0) ftype = 8'($urandom_range(0, 2));
        else ftype = 8'($urandom_range(0, 255));
        tinfo = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        build_record(dtype, ftype, tinfo, 8'($urandom_range(0, 255)),
                     (r < 30) ? int'($urandom_range(0, 4)) : -1,
                     ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 20)) : 0);
    endfunction

    // Files shorter than the window: a lone last byte, a bare signature, and
    // one byte short of a full window.
    task automatic test_short_files();
        build_short(1, 1'b0);
        send_file();
        build_short(5, 1'b1);
        send_file();
        build_short(WINDOW_LEN - 1, 1'b1);
        send_file();
    endtask

    // Signature and type checks, with column counts at both ends.
    task automatic test_record_types();
        set_font("IBM VGA");
        build_record(DT_CHARACTER, 8'd0, 8'd80, 8'h00, 2, 0);
        send_file();
        build_record(DT_CHARACTER, 8'd2, 8'd0, 8'h00, -1, 0);
        send_file();
        build_record(DT_CHARACTER, 8'd3, 8'd80, 8'h00, -1, 0);
        send_file();
        build_record(DT_BINARY, 8'hFF, 8'd0, 8'h00, -1, 0);
        send_file();
        build_record(8'h00, 8'd0, 8'd80, 8'h00, -1, 0);
        send_file();
        build_record(8'hFF, 8'd0, 8'd80, 8'h00, -1, 0);
        send_file();
    endtask

    // Letter-width and aspect field values one to three, ice colors on and off.
    task automatic test_flag_decoding();
        set_font("Terminus");
        build_record(DT_CHARACTER, 8'd1, 8'hFF, 8'h0B, -1, 0);
        send_file();
        build_record(DT_CHARACTER, 8'd1, 8'd1, 8'h14, -1, 0);
        send_file();
        build_record(DT_CHARACTER, 8'd0, 8'd160, 8'hFF, -1, 0);
        send_file();
    endtask

    // Every font branch, including an empty name, a saturating digit run and
    // a name that fills the field with no terminator.
    task automatic test_font_names();
        for (int i = 0; i < NUM_BASE_FONTS; i++) begin
            set_font(base_font(i));
            build_record(DT_CHARACTER, 8'd0, 8'd80, 8'h00, -1, 0);
            send_file();
        end
    endtask

    // Bytes past the window are dropped; the last one still closes the file.
    task automatic test_window_overflow();
        set_font("Amiga Topaz 2+");
        build_record(DT_CHARACTER, 8'd0, 8'd80, 8'h12, -1, 1);
        send_file();
        set_font("Spleen");
        build_record(DT_BINARY, 8'd40, 8'd0, 8'h09, -1, 30);
        send_file();
    endtask

    // With use_sauce cleared a valid record is only reported, not applied.
    task automatic test_use_sauce_off();
        write_use_sauce(1'b0);
        set_font("IBM VGA 850");
        build_record(DT_CHARACTER, 8'd0, 8'd80, 8'h0B, -1, 0);
        send_file();
        build_record(DT_BINARY, 8'd7, 8'd0, 8'hFF, -1, 0);
        send_file();
        write_use_sauce(1'b1);
    endtask

    // The receiver holds off while short files keep coming, so a result waits
    // in the output register, the next last byte holds in the input register and
    // the input stalls. Then the sender waits for everything to drain.
    task automatic test_output_backpressure();
        rx_hold_req = LONG_HOLD_CYCLES;
        sender_gaps = 1'b0;
        for (int i = 0; i < 8; i++) begin
            build_short($urandom_range(1, 4), 1'b0);
            send_file();
        end
        set_font("Amiga MicroKnight+");
        build_record(DT_CHARACTER, 8'd2, 8'd132, 8'h05, -1, 3);
        send_file();
        sender_gaps = 1'b1;
        wait_idle();
    endtask

    // Random files in four phases with use_sauce set, cleared, random and set again; the third
    // phase runs the sender with no gaps at all.
    task automatic test_random_stream();
        int phase_bytes;
        int phase_files;
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 1) write_use_sauce(1'b0);
            else if (ph == 2) write_use_sauce(1'($urandom_range(0, 1)));
            else write_use_sauce(1'b1);
            sender_gaps = (ph != 2);
            phase_bytes = 0;
            phase_files = 0;
            while (phase_bytes < RANDOM_BYTES / 4 || phase_files < MIN_RANDOM_FILES / 4) begin
                make_random_file();
                phase_bytes += file_q.size();
                send_file();
                phase_files++;
            end
        end
        sender_gaps = 1'b1;
    endtask

    initial begin
        clear_parser();
        for (int i = 0; i < 8; i++) status_hits[i] = 0;
        // Reset is held at the start and never asserted again.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_short_files();
        test_record_types();
        test_flag_decoding();
        test_font_names();
        test_window_overflow();
        test_use_sauce_off();
        test_output_backpressure();
        test_random_stream();

        // Let the last results out, then watch a little longer for strays.
        wait_idle();
        repeat (4 * DRAIN_CYCLES) @(posedge aclk);
        if (expected_q.size() != 0)
            report_error($sformatf("%0d expected results never arrived", expected_q.size()));

        $display("Sent %0d files in %0d bytes, checked %0d results, wrote use_sauce %0d times.",
                 files_sent, bytes_sent, results_checked, cfg_writes);
        $display("Results by status 0..6: %0d %0d %0d %0d %0d %0d %0d; mismatches: %0d.",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5], status_hits[6], error_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
